// ----- rtl/ptc_pkg.sv -----
// package for the pressure / temperature compensation block
// types, register indexes and sequencer states; no dependencies
package ptc_pkg;

  localparam int unsigned CfgWidth = 64;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned RawWidth = 20;

  localparam logic [CfgIdxWidth-1:0] RegTempCal = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegPresLow = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegPresMid = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegPresHigh = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T0, S_T1, S_T2, S_T3, S_T4,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
    S_DIV,
    S_Q0, S_Q1, S_Q2, S_Q3,
    S_OUT
  } state_e;

  // one operation of the shared multiplier
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/ptc_if.sv -----
// valid/ready channels of the compensation block
// depends on ptc_pkg
interface ptc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [ptc_pkg::RawWidth-1:0]   raw_sample;
  modport source (output valid, output mode, output raw_sample, input ready);
  modport sink (input valid, input mode, input raw_sample, output ready);
endinterface

interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic [31:0]        pressure_q24_8;
  logic               pressure_invalid;
  modport source (output valid, output temperature_centi, output pressure_q24_8,
                  output pressure_invalid, input ready);
  modport sink (input valid, input temperature_centi, input pressure_q24_8,
                input pressure_invalid, output ready);
endinterface

// ----- rtl/pressure_temperature_compensation_unit.sv -----
// Pressure / temperature compensation for a barometric sensor.
// Input channel in_if carries a mode bit (0 temperature, 1 pressure) and a
// 20-bit raw reading; output channel out_if gives one result item per input
// item: temperature in 0.01 degree units, or pressure in pascals times 256
// with an invalid flag when the pressure divisor is zero.
// Calibration is written via cfg_we_i / cfg_idx_i / cfg_data_i; the user must
// do so while idle (not enforced): index 0 T1..T3, 1 P1..P4, 2 P5..P8, 3 P9.
// One item at a time: a temperature item uses three products on the shared
// multiplier, a pressure item ten products and the restoring divider, ending
// before the divider when the divisor is zero. The multiplier and divider set
// the rate; the next item is taken at the earliest in the cycle after the
// result has been delivered.
// in_if.ready is high only when the sequencer is idle; the result waits in
// the output register for as long as the receiver stalls, and the next item
// is taken once it has been delivered.
// Reset clears the calibration registers and the fine temperature to zero.
module pressure_temperature_compensation_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ptc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [ptc_pkg::CfgWidth-1:0]        cfg_data_i,
  ptc_in_if.sink                              in_if,
  ptc_out_if.source                           out_if
);

  ptc_pkg::state_e state_q, state_d;
  logic [47:0] tcal_q;
  logic [63:0] plow_q, pmid_q;
  logic [15:0] phigh_q;
  logic [31:0] tfine_q;
  logic [19:0] adc_q;
  logic [63:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d;
  logic [2:0]  wait_q, wait_d;
  logic        inv_q, inv_d, ovalid_q, ovalid_d, mode_q;
  logic [31:0] otemp_q, otemp_d, opres_q, opres_d;
  logic [31:0] tfine_d;

  logic              mul_start;
  ptc_pkg::mul_req_t mul_req;
  logic              mul_done;
  logic [63:0]       prod;
  ptc_pkg::div_req_t div_req;
  ptc_pkg::div_rsp_t div_rsp;

  ptc_mul u_mul (.clk_i, .rst_ni, .start_i(mul_start), .req_i(mul_req),
                 .done_o(mul_done), .prod_o(prod));
  ptc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // calibration words
  function automatic logic [63:0] sx(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, tf;
  assign t1 = {48'd0, tcal_q[15:0]};
  assign t2 = sx(tcal_q[31:16]);
  assign t3 = sx(tcal_q[47:32]);
  assign p1 = {48'd0, plow_q[15:0]};
  assign p2 = sx(plow_q[31:16]);
  assign p3 = sx(plow_q[47:32]);
  assign p4 = sx(plow_q[63:48]);
  assign p5 = sx(pmid_q[15:0]);
  assign p6 = sx(pmid_q[31:16]);
  assign p7 = sx(pmid_q[47:32]);
  assign p8 = sx(pmid_q[63:48]);
  assign p9 = sx(phigh_q);
  assign tf = {{32{tfine_q[31]}}, tfine_q};

  // multiplier result is taken when the wait counter, loaded at its start, reaches one
  logic mul_ready;
  assign mul_ready = (wait_q == 3'd1);

  function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction
  function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
    return 64'($signed(x) >>> n);
  endfunction

  assign in_if.ready = (state_q == ptc_pkg::S_IDLE) && !ovalid_q;

  // next state and datapath sequencing
  always_comb begin
    state_d = state_q;
    r0_d = r0_q; r1_d = r1_q; r2_d = r2_q;
    wait_d = (wait_q != 3'd0) ? wait_q - 3'd1 : 3'd0;
    inv_d = inv_q; otemp_d = otemp_q; opres_d = opres_q;
    tfine_d = tfine_q;
    ovalid_d = ovalid_q && !out_if.ready;
    mul_start = 1'b0;
    mul_req = '0;
    div_req = '0;
    unique case (state_q)
      ptc_pkg::S_IDLE: begin
        if (in_if.valid && in_if.ready) begin
          mul_start = 1'b1;
          wait_d = 3'd5;
          if (!in_if.mode) begin
            // d1 * t2
            mul_req.a = {44'd0, 20'({3'd0, in_if.raw_sample[19:3]})} - (t1 << 1);
            mul_req.b = t2;
            state_d = ptc_pkg::S_T0;
          end else begin
            // a = tf - 128000, a*a
            mul_req.a = tf - 64'd128000;
            mul_req.b = tf - 64'd128000;
            r0_d = tf - 64'd128000;
            state_d = ptc_pkg::S_P0;
          end
        end
      end
      ptc_pkg::S_T0: if (mul_ready) begin
        r1_d = {32'd0, asr32(prod[31:0], 11)};
        r2_d = {48'd0, 16'(adc_q >> 4)} - t1;
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = {48'd0, 16'(adc_q >> 4)} - t1;
        mul_req.b = {48'd0, 16'(adc_q >> 4)} - t1;
        state_d = ptc_pkg::S_T1;
      end
      ptc_pkg::S_T1: if (mul_ready) begin
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = {{32{prod[31]}}, asr32(prod[31:0], 12)};
        mul_req.b = t3;
        state_d = ptc_pkg::S_T2;
      end
      ptc_pkg::S_T2: if (mul_ready) begin
        tfine_d = r1_q[31:0] + asr32(prod[31:0], 14);
        otemp_d = asr32((r1_q[31:0] + asr32(prod[31:0], 14)) * 32'd5 + 32'd128, 8);
        opres_d = '0; inv_d = 1'b0;
        state_d = ptc_pkg::S_OUT;
      end
      ptc_pkg::S_P0: if (mul_ready) begin
        r1_d = prod; // a*a
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = prod; mul_req.b = p6;
        state_d = ptc_pkg::S_P1;
      end
      ptc_pkg::S_P1: if (mul_ready) begin
        r2_d = prod + (p4 << 35); // b partial
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = r0_q; mul_req.b = p5;
        state_d = ptc_pkg::S_P2;
      end
      ptc_pkg::S_P2: if (mul_ready) begin
        r2_d = r2_q + (prod << 17); // b done
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = r1_q; mul_req.b = p3;
        state_d = ptc_pkg::S_P3;
      end
      ptc_pkg::S_P3: if (mul_ready) begin
        r1_d = asr64(prod, 8);
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = r0_q; mul_req.b = p2;
        state_d = ptc_pkg::S_P4;
      end
      ptc_pkg::S_P4: if (mul_ready) begin
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = (64'd1 << 47) + r1_q + (prod << 12);
        mul_req.b = p1;
        state_d = ptc_pkg::S_P5;
      end
      ptc_pkg::S_P5: if (mul_ready) begin
        r1_d = asr64(prod, 33); // divisor
        if (asr64(prod, 33) == 64'd0) begin
          inv_d = 1'b1; opres_d = '0; otemp_d = '0;
          state_d = ptc_pkg::S_OUT;
        end else begin
          mul_start = 1'b1; wait_d = 3'd5;
          mul_req.a = ({44'd0, 20'd0} + ((64'd1048576 - {44'd0, adc_q}) << 31)) - r2_q;
          mul_req.b = 64'd3125;
          state_d = ptc_pkg::S_P6;
        end
      end
      ptc_pkg::S_P6: if (mul_ready) begin
        div_req.start = 1'b1;
        div_req.num = prod;
        div_req.den = r1_q;
        state_d = ptc_pkg::S_DIV;
      end
      ptc_pkg::S_DIV: if (div_rsp.done) begin
        r0_d = div_rsp.quot; // p
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = p9; mul_req.b = asr64(div_rsp.quot, 13);
        state_d = ptc_pkg::S_Q0;
      end
      ptc_pkg::S_Q0: if (mul_ready) begin
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = prod; mul_req.b = asr64(r0_q, 13);
        state_d = ptc_pkg::S_Q1;
      end
      ptc_pkg::S_Q1: if (mul_ready) begin
        r1_d = asr64(prod, 25);
        mul_start = 1'b1; wait_d = 3'd5;
        mul_req.a = p8; mul_req.b = r0_q;
        state_d = ptc_pkg::S_Q2;
      end
      ptc_pkg::S_Q2: if (mul_ready) begin
        r2_d = asr64(r0_q + r1_q + asr64(prod, 19), 8) + (p7 << 4);
        state_d = ptc_pkg::S_Q3;
      end
      ptc_pkg::S_Q3: begin
        opres_d = r2_q[31:0]; inv_d = 1'b0; otemp_d = '0;
        state_d = ptc_pkg::S_OUT;
      end
      ptc_pkg::S_OUT: begin
        ovalid_d = 1'b1;
        state_d = ptc_pkg::S_IDLE;
      end
      default: state_d = ptc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptc_pkg::S_IDLE;
      wait_q <= '0;
      ovalid_q <= 1'b0;
      tcal_q <= '0; plow_q <= '0; pmid_q <= '0; phigh_q <= '0;
      tfine_q <= '0;
    end else begin
      state_q <= state_d;
      wait_q <= wait_d;
      ovalid_q <= ovalid_d;
      tfine_q <= tfine_d;
      // calibration writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ptc_pkg::RegTempCal:  tcal_q <= cfg_data_i[47:0];
          ptc_pkg::RegPresLow:  plow_q <= cfg_data_i;
          ptc_pkg::RegPresMid:  pmid_q <= cfg_data_i;
          ptc_pkg::RegPresHigh: phigh_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d; r1_q <= r1_d; r2_q <= r2_d;
    inv_q <= inv_d; otemp_q <= otemp_d; opres_q <= opres_d;
    if (in_if.valid && in_if.ready) begin
      adc_q <= in_if.raw_sample;
      mode_q <= in_if.mode;
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.temperature_centi = mode_q ? 32'sd0 : $signed(otemp_q);
  assign out_if.pressure_q24_8 = mode_q ? opres_q : 32'd0;
  assign out_if.pressure_invalid = mode_q & inv_q;

`ifndef NO_ASSERTIONS
  // no item accepted while a result is pending
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("accept while result pending");
  // divider only runs in the division state
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == ptc_pkg::S_DIV)) else $error("divider stray");
  // stalled result keeps valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
  // sequencer samples the product exactly when the multiplier has finished
  a_mul_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_ready |-> mul_done) else $error("product taken early");
`endif

endmodule

// ----- rtl/ptc_mul.sv -----
// shared 64-bit wrapping multiplier built from 32x32 partial products lo*lo, lo*hi and hi*lo
// depends on ptc_pkg
module ptc_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ptc_pkg::mul_req_t req_i,
  output logic              done_o,
  output logic [63:0]       prod_o
);

  logic [63:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [31:0] pa, pb;
  logic [63:0] pp_q;

  // pick partial product: lo*lo, lo*hi, hi*lo
  always_comb begin
    case (cnt_q)
      3'd3:    begin pa = a_q[31:0];  pb = b_q[31:0];  end
      3'd2:    begin pa = a_q[31:0];  pb = b_q[63:32]; end
      default: begin pa = a_q[63:32]; pb = b_q[31:0];  end
    endcase
  end

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d = req_i.a;
      b_d = req_i.b;
      acc_d = '0;
      cnt_d = 3'd4;
    end else if (cnt_q != 3'd0) begin
      cnt_d = cnt_q - 3'd1;
      done_d = (cnt_q == 3'd1);
      // product of the previous cycle accumulates
      case (cnt_q)
        3'd2:    acc_d = pp_q;
        3'd1:    acc_d = acc_q + {pp_q[31:0], 32'd0};
        default: acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    acc_q <= acc_d;
    pp_q <= 64'(pa) * 64'(pb);
  end

  // last cross term lands straight in the result
  assign prod_o = acc_q + {pp_q[31:0], 32'd0};
  // high for the one cycle in which the full product is on prod_o
  assign done_o = done_q;

endmodule

// ----- rtl/ptc_div.sv -----
// signed 64-bit restoring divider, one quotient bit a cycle, truncates toward zero
// depends on ptc_pkg
module ptc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptc_pkg::div_req_t req_i,
  output ptc_pkg::div_rsp_t rsp_o
);

  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, done_q, done_d;
  logic [64:0] trial;
  logic [63:0] shifted;

  assign shifted = {rem_q[62:0], quo_q[63]};
  assign trial = {1'b0, shifted} - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.num[63] ? (64'd0 - req_i.num) : req_i.num;
      den_d = req_i.den[63] ? (64'd0 - req_i.den) : req_i.den;
      neg_d = req_i.num[63] ^ req_i.den[63];
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      // one restoring step
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      done_d = (cnt_q == 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy = (cnt_q != 7'd0);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule
